@@ rtl/core/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF   = 256;
    localparam int HEADER_BYTES_DEF = 4;

    localparam int OFFSET_W    = 24;
    localparam int SLOT_W      = 17;
    localparam int COUNT_CFG_W = 9;
    localparam int IDX_OUT_W   = 8;
    localparam int FREE_OUT_W  = 9;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 17;

    localparam logic [SLOT_W-1:0]      SLOT_SIZE_RST   = SLOT_W'(68);
    localparam logic [COUNT_CFG_W-1:0] BLOCK_COUNT_RST = COUNT_CFG_W'(256);

    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_SIZE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD      = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                done;
        logic [OFFSET_W-1:0] quot;
        logic [SLOT_W-1:0]   rem;
    } div_res_t;

endpackage

@@ rtl/core/fbpa_if.sv @@
// ----------------------------------------------------------------------------
// fbpa_if
// request and response channels of the fixed block pool allocator
// ----------------------------------------------------------------------------
interface fbpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [fbpa_pkg::OFFSET_W-1:0] release_offset;

    modport source (output valid, output req_type, output release_offset, input ready);
    modport sink   (input valid, input req_type, input release_offset, output ready);
endinterface

interface fbpa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [fbpa_pkg::STATUS_W-1:0]   status;
    logic [fbpa_pkg::OFFSET_W-1:0]   user_offset;
    logic [fbpa_pkg::IDX_OUT_W-1:0]  slot_index;
    logic [fbpa_pkg::FREE_OUT_W-1:0] free_count;

    modport source (output valid, output status, output user_offset, output slot_index,
                    output free_count, input ready);
    modport sink   (input valid, input status, input user_offset, input slot_index,
                    input free_count, output ready);
endinterface

@@ rtl/core/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/fbpa_div.sv @@
// ----------------------------------------------------------------------------
// fbpa_div
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
module fbpa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fbpa_pkg::OFFSET_W-1:0] dividend,
    input  logic [fbpa_pkg::SLOT_W-1:0]   divisor,
    output fbpa_pkg::div_res_t            res
);

    localparam int CNT_W = $clog2(fbpa_pkg::OFFSET_W + 1);

    logic [fbpa_pkg::SLOT_W-1:0]   rem_reg, rem_next;
    logic [fbpa_pkg::OFFSET_W-1:0] quo_reg, quo_next;
    logic [fbpa_pkg::SLOT_W-1:0]   dsr_reg, dsr_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [fbpa_pkg::SLOT_W:0]     trial;
    logic                          ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[fbpa_pkg::OFFSET_W-1]};
        ge        = trial >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = CNT_W'(fbpa_pkg::OFFSET_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? fbpa_pkg::SLOT_W'(trial - {1'b0, dsr_reg})
                           : trial[fbpa_pkg::SLOT_W-1:0];
            quo_next  = {quo_reg[fbpa_pkg::OFFSET_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg;

endmodule

@@ rtl/core/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// fixed size block allocator on a lifo stack of free slot indices
// ----------------------------------------------------------------------------
// req carries one beat per request: req_type 0 acquires a block, 1 releases
// the user area at release_offset. rsp returns exactly one beat per request
// with status, user_offset, slot_index and the free count after the request.
// the free stack sits in one ram with a registered read; a low-water mark
// tells which entries still hold their reload value, so reset and a write of
// block_count refill the stack at once, with no clearing pass.
// an acquire goes through S_RD (index select from the ram read), S_MUL
// (multiply by the slot size) and S_DONE (output load). a release sends the
// 24-bit offset through a restoring divider at one quotient bit per cycle,
// then the check and the push. an acquire on an empty pool or a release
// below the header goes straight to the output load. a new request is
// accepted in the cycle after the previous result is loaded. rsp is a
// holding register: when the receiver stalls, a finished result waits there
// while the next request is already taken and worked on; that one waits for
// the register before it commits. configuration is written through cfg_we,
// cfg_index and cfg_data while idle; the user ensures it, not the block.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS   = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    fbpa_req_if.sink                         req,
    fbpa_rsp_if.source                       rsp
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W = IDX_W + fbpa_pkg::SLOT_W;

    function automatic logic [CNT_W-1:0] eff_count(
        input logic [fbpa_pkg::COUNT_CFG_W-1:0] bc
    );
        logic [CNT_W-1:0] n;
        if (bc == '0)
        begin
            n = CNT_W'(1);
        end
        else if (32'(bc) > MAX_BLOCKS)
        begin
            n = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            n = CNT_W'(bc);
        end
        return n;
    endfunction

    fbpa_pkg::state_t                  state_reg, state_next;
    logic [fbpa_pkg::SLOT_W-1:0]       ss_reg, ss_next;
    logic [fbpa_pkg::COUNT_CFG_W-1:0]  bc_reg, bc_next;
    logic [CNT_W-1:0]                  fc_reg, fc_next;
    logic [CNT_W-1:0]                  lwm_reg, lwm_next;
    logic [CNT_W-1:0]                  top_reg, top_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [IDX_W-1:0]                  push_val_reg, push_val_next;
    logic [PROD_W-1:0]                 prod_reg, prod_next;
    fbpa_pkg::status_t                 status_reg, status_next;
    logic [fbpa_pkg::IDX_OUT_W-1:0]    idx_out_reg, idx_out_next;
    logic                              has_uoff_reg, has_uoff_next;
    logic                              pop_reg, pop_next;
    logic                              push_reg, push_next;
    logic                              out_valid_reg, out_valid_next;
    fbpa_pkg::status_t                 out_status_reg, out_status_next;
    logic [fbpa_pkg::OFFSET_W-1:0]     out_uoff_reg, out_uoff_next;
    logic [fbpa_pkg::IDX_OUT_W-1:0]    out_idx_reg, out_idx_next;
    logic [fbpa_pkg::FREE_OUT_W-1:0]   out_fc_reg, out_fc_next;

    logic [fbpa_pkg::SLOT_W-1:0]       s_eff;
    logic [CNT_W-1:0]                  n_eff;
    logic [CNT_W-1:0]                  reload_n;
    logic [CNT_W-1:0]                  dflt_idx;
    logic [CNT_W-1:0]                  fc_after;
    logic [PROD_W:0]                   uoff_sum;
    logic                              ram_we, ram_re;
    logic [IDX_W-1:0]                  ram_waddr, ram_raddr, ram_rdata;
    logic                              div_start;
    logic [fbpa_pkg::OFFSET_W-1:0]     div_dividend;
    fbpa_pkg::div_res_t                div_res;

    assign s_eff = (ss_reg < fbpa_pkg::SLOT_W'(HEADER_BYTES + 1))
                   ? fbpa_pkg::SLOT_W'(HEADER_BYTES + 1) : ss_reg;
    assign n_eff        = eff_count(bc_reg);
    assign reload_n     = eff_count(cfg_data[fbpa_pkg::COUNT_CFG_W-1:0]);
    assign dflt_idx     = n_eff - CNT_W'(1) - top_reg;
    assign uoff_sum     = {1'b0, prod_reg} + (PROD_W + 1)'(HEADER_BYTES);
    assign div_dividend = req.release_offset - fbpa_pkg::OFFSET_W'(HEADER_BYTES);
    assign ram_waddr    = fc_reg[IDX_W-1:0];

    always_comb
    begin
        fc_after = fc_reg;
        if (pop_reg)
        begin
            fc_after = fc_reg - CNT_W'(1);
        end
        else if (push_reg)
        begin
            fc_after = fc_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ss_next         = ss_reg;
        bc_next         = bc_reg;
        fc_next         = fc_reg;
        lwm_next        = lwm_reg;
        top_next        = top_reg;
        idx_next        = idx_reg;
        push_val_next   = push_val_reg;
        prod_next       = prod_reg;
        status_next     = status_reg;
        idx_out_next    = idx_out_reg;
        has_uoff_next   = has_uoff_reg;
        pop_next        = pop_reg;
        push_next       = push_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_uoff_next   = out_uoff_reg;
        out_idx_next    = out_idx_reg;
        out_fc_next     = out_fc_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = top_reg[IDX_W-1:0];
        div_start       = 1'b0;
        req.ready       = (state_reg == fbpa_pkg::S_IDLE);

        case (state_reg)
            fbpa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    status_next   = fbpa_pkg::ST_OK;
                    idx_out_next  = '0;
                    has_uoff_next = 1'b0;
                    pop_next      = 1'b0;
                    push_next     = 1'b0;
                    if (!req.req_type)
                    begin
                        if (fc_reg == '0)
                        begin
                            status_next = fbpa_pkg::ST_EMPTY;
                            state_next  = fbpa_pkg::S_DONE;
                        end
                        else
                        begin
                            top_next      = fc_reg - CNT_W'(1);
                            ram_raddr     = top_next[IDX_W-1:0];
                            ram_re        = 1'b1;
                            has_uoff_next = 1'b1;
                            pop_next      = 1'b1;
                            state_next    = fbpa_pkg::S_RD;
                        end
                    end
                    else if (req.release_offset < fbpa_pkg::OFFSET_W'(HEADER_BYTES))
                    begin
                        status_next = fbpa_pkg::ST_BAD;
                        state_next  = fbpa_pkg::S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = fbpa_pkg::S_DIV;
                    end
                end
            end
            fbpa_pkg::S_RD:
            begin
                // entries below the low-water mark still hold the reload value
                idx_next   = (top_reg < lwm_reg) ? dflt_idx[IDX_W-1:0] : ram_rdata;
                state_next = fbpa_pkg::S_MUL;
            end
            fbpa_pkg::S_MUL:
            begin
                prod_next    = PROD_W'(idx_reg) * PROD_W'(s_eff);
                idx_out_next = fbpa_pkg::IDX_OUT_W'(32'(idx_reg));
                state_next   = fbpa_pkg::S_DONE;
            end
            fbpa_pkg::S_DIV:
            begin
                if (div_res.done)
                begin
                    if (div_res.rem != '0 || 32'(div_res.quot) >= 32'(n_eff))
                    begin
                        status_next = fbpa_pkg::ST_BAD;
                    end
                    else
                    begin
                        idx_out_next  = div_res.quot[fbpa_pkg::IDX_OUT_W-1:0];
                        push_val_next = div_res.quot[IDX_W-1:0];
                        if (fc_reg >= n_eff)
                        begin
                            status_next = fbpa_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            push_next = 1'b1;
                        end
                    end
                    state_next = fbpa_pkg::S_DONE;
                end
            end
            fbpa_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_uoff_next   = has_uoff_reg ? fbpa_pkg::OFFSET_W'(uoff_sum) : '0;
                    out_idx_next    = idx_out_reg;
                    out_fc_next     = fbpa_pkg::FREE_OUT_W'(32'(fc_after));
                    fc_next         = fc_after;
                    if (pop_reg && top_reg < lwm_reg)
                    begin
                        lwm_next = top_reg;
                    end
                    ram_we     = push_reg;
                    state_next = fbpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                fbpa_pkg::CFG_SLOT_SIZE:
                begin
                    ss_next = cfg_data[fbpa_pkg::SLOT_W-1:0];
                end
                fbpa_pkg::CFG_BLOCK_COUNT:
                begin
                    bc_next  = cfg_data[fbpa_pkg::COUNT_CFG_W-1:0];
                    fc_next  = reload_n;
                    lwm_next = reload_n;
                end
                default:
                begin
                    ss_next = ss_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fbpa_pkg::S_IDLE;
            ss_reg        <= fbpa_pkg::SLOT_SIZE_RST;
            bc_reg        <= fbpa_pkg::BLOCK_COUNT_RST;
            fc_reg        <= eff_count(fbpa_pkg::BLOCK_COUNT_RST);
            lwm_reg       <= eff_count(fbpa_pkg::BLOCK_COUNT_RST);
            pop_reg       <= 1'b0;
            push_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ss_reg        <= ss_next;
            bc_reg        <= bc_next;
            fc_reg        <= fc_next;
            lwm_reg       <= lwm_next;
            pop_reg       <= pop_next;
            push_reg      <= push_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        idx_reg        <= idx_next;
        push_val_reg   <= push_val_next;
        prod_reg       <= prod_next;
        status_reg     <= status_next;
        idx_out_reg    <= idx_out_next;
        has_uoff_reg   <= has_uoff_next;
        out_status_reg <= out_status_next;
        out_uoff_reg   <= out_uoff_next;
        out_idx_reg    <= out_idx_next;
        out_fc_reg     <= out_fc_next;
    end

    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_val_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (s_eff),
        .res      (div_res)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.user_offset = out_uoff_reg;
    assign rsp.slot_index  = out_idx_reg;
    assign rsp.free_count  = out_fc_reg;

`ifndef ASSERT_OFF
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= n_eff)
        else $error("free count above block count");

    a_lwm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lwm_reg <= fc_reg)
        else $error("low-water mark above free count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != fbpa_pkg::S_IDLE)
        else $error("request accepted but no work started");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == fbpa_pkg::ST_EMPTY |-> rsp.free_count == '0)
        else $error("empty status with free slots left");
`endif

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fixed block pool allocator: a free-stack model
// predicts every rsp beat from the accepted req beats and the register
// writes; directed corner cases come first, then random acquire and release
// traffic over several pool settings with random gaps and stalls
// ----------------------------------------------------------------------------
typedef struct packed {
    fbpa_pkg::status_t                    status;
    logic [fbpa_pkg::OFFSET_W-1:0]        user_offset;
    logic [fbpa_pkg::IDX_OUT_W-1:0]       slot_index;
    logic [fbpa_pkg::FREE_OUT_W-1:0]      free_count;
} pool_rsp_t;

class pool_scoreboard;
    localparam int HDR  = fbpa_pkg::HEADER_BYTES_DEF;
    localparam int MAXB = fbpa_pkg::MAX_BLOCKS_DEF;

    logic [fbpa_pkg::SLOT_W-1:0]      slot_size;
    logic [fbpa_pkg::COUNT_CFG_W-1:0] block_count;
    logic [fbpa_pkg::IDX_OUT_W-1:0]   free_stack [MAXB];
    int unsigned                      free_slots;
    pool_rsp_t                        pending [$];
    int                               errors;
    int                               status_seen [4];

    function void clear();
        slot_size   = fbpa_pkg::SLOT_SIZE_RST;
        block_count = fbpa_pkg::BLOCK_COUNT_RST;
        errors      = 0;
        pending.delete();
        foreach (status_seen[i])
            status_seen[i] = 0;
        reload();
    endfunction

    function int unsigned eff_slot();
        int unsigned s;
        s = slot_size;
        if (s < HDR + 1)
            s = HDR + 1;
        return s;
    endfunction

    function int unsigned eff_count();
        int unsigned n;
        n = block_count;
        if (n < 1)
            n = 1;
        if (n > MAXB)
            n = MAXB;
        return n;
    endfunction

    function void reload();
        int unsigned n;
        n = eff_count();
        for (int i = 0; i < MAXB; i++)
            free_stack[i] = (i < n) ? 8'(n - 1 - i) : 8'd0;
        free_slots = n;
    endfunction

    function void write_reg(logic [fbpa_pkg::CFG_INDEX_W-1:0] idx,
                            logic [fbpa_pkg::CFG_DATA_W-1:0] data);
        if (idx == fbpa_pkg::CFG_SLOT_SIZE)
            slot_size = data;
        else
        begin
            block_count = data[fbpa_pkg::COUNT_CFG_W-1:0];
            reload();
        end
    endfunction

    function pool_rsp_t note_request(bit is_release, logic [fbpa_pkg::OFFSET_W-1:0] off);
        pool_rsp_t       r;
        int unsigned     s, n, top, rel_off, q;
        longint unsigned wide;
        s = eff_slot();
        n = eff_count();
        r.status      = fbpa_pkg::ST_OK;
        r.user_offset = '0;
        r.slot_index  = '0;
        if (!is_release)
        begin
            if (free_slots == 0)
                r.status = fbpa_pkg::ST_EMPTY;
            else
            begin
                top          = free_slots - 1;
                r.slot_index = free_stack[top];
                free_slots   = top;
                wide         = r.slot_index * s + HDR;
                r.user_offset = wide[fbpa_pkg::OFFSET_W-1:0];
            end
        end
        else if (off < HDR)
            r.status = fbpa_pkg::ST_BAD;
        else
        begin
            rel_off = off - HDR;
            q       = rel_off / s;
            if ((rel_off % s) != 0 || q >= n)
                r.status = fbpa_pkg::ST_BAD;
            else
            begin
                r.slot_index = q[7:0];
                if (free_slots >= n)
                    r.status = fbpa_pkg::ST_OVERFLOW;
                else
                begin
                    free_stack[free_slots] = q[7:0];
                    free_slots++;
                end
            end
        end
        r.free_count = free_slots[fbpa_pkg::FREE_OUT_W-1:0];
        pending.push_back(r);
        return r;
    endfunction

    task report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch on %s: got %0d expected %0d", field, got, want);
        errors++;
    endtask

    task check_result(logic [fbpa_pkg::STATUS_W-1:0] status,
                      logic [fbpa_pkg::OFFSET_W-1:0] user_offset,
                      logic [fbpa_pkg::IDX_OUT_W-1:0] slot_index,
                      logic [fbpa_pkg::FREE_OUT_W-1:0] free_count);
        pool_rsp_t want;
        if (pending.size() == 0)
        begin
            report_mismatch("rsp beat with no request waiting", status, 0);
            return;
        end
        want = pending.pop_front();
        status_seen[want.status]++;
        if (status !== want.status)
            report_mismatch("status", status, want.status);
        if (user_offset !== want.user_offset)
            report_mismatch("user_offset", user_offset, want.user_offset);
        if (slot_index !== want.slot_index)
            report_mismatch("slot_index", slot_index, want.slot_index);
        if (free_count !== want.free_count)
            report_mismatch("free_count", free_count, want.free_count);
    endtask
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 175;
    localparam int CHUNK        = 25;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    int          cycles    = 0;
    int          requests  = 0;
    int          cfg_writes = 0;
    int unsigned held [$];
    pool_scoreboard pool;

    fbpa_req_if req ();
    fbpa_rsp_if rsp ();

    fixed_block_pool_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            pool.check_result(rsp.status, rsp.user_offset, rsp.slot_index, rsp.free_count);
    end

    task set_mode(int mode);
        case (mode)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 84;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 84;
            end
            default:
            begin
                idle_pct  = 27;
                stall_pct = 27;
            end
        endcase
    endtask

    task send_request(bit is_release, logic [fbpa_pkg::OFFSET_W-1:0] off);
        pool_rsp_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.req_type       <= is_release;
        req.release_offset <= off;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        r = pool.note_request(is_release, off);
        requests++;
        if (r.status == fbpa_pkg::ST_OK)
        begin
            if (!is_release)
                held.push_back(r.slot_index);
            else
            begin
                foreach (held[i])
                begin
                    if (held[i] == r.slot_index)
                    begin
                        held.delete(i);
                        break;
                    end
                end
            end
        end
    endtask

    // pool idle: no request in flight and every rsp beat taken
    task settle();
        req.valid <= 1'b0;
        while (pool.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_reg(logic [fbpa_pkg::CFG_INDEX_W-1:0] idx,
                   logic [fbpa_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        pool.write_reg(idx, data);
        if (idx == fbpa_pkg::CFG_BLOCK_COUNT)
            held.delete();
        cfg_writes++;
        @(posedge clk);
    endtask

    function logic [fbpa_pkg::OFFSET_W-1:0] slot_offset(int unsigned q);
        longint unsigned wide;
        wide = q * pool.eff_slot() + fbpa_pkg::HEADER_BYTES_DEF;
        return wide[fbpa_pkg::OFFSET_W-1:0];
    endfunction

    task random_item(int acq_pct);
        int unsigned pick;
        logic [fbpa_pkg::OFFSET_W-1:0] off;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < acq_pct)
            send_request(1'b0, fbpa_pkg::OFFSET_W'($urandom));
        else
        begin
            if (pick < 65 && held.size() != 0)
                off = slot_offset(held[$urandom_range(0, held.size() - 1)]);
            else if (pick < 80)
                off = slot_offset($urandom_range(0, pool.eff_count() + 1));
            else if (pick < 88)
                off = fbpa_pkg::OFFSET_W'(slot_offset($urandom_range(0, pool.eff_count() - 1))
                      + ($urandom_range(0, 1) ? 1 : -1));
            else if (pick < 93)
                off = fbpa_pkg::OFFSET_W'($urandom_range(0, fbpa_pkg::HEADER_BYTES_DEF - 1));
            else
                off = fbpa_pkg::OFFSET_W'($urandom);
            send_request(1'b1, off);
        end
    endtask

    task directed();
        send_request(1'b0, '0);
        send_request(1'b1, 24'd4);
        send_request(1'b1, 24'd4);
        send_request(1'b1, 24'd0);
        send_request(1'b1, 24'd3);
        send_request(1'b1, 24'd5);
        send_request(1'b1, 24'd72);
        send_request(1'b1, 24'd4 + 24'd68 * 24'd256);
        send_request(1'b1, 24'hFFFFFF);
        send_request(1'b0, 24'hFFFFFF);
        send_request(1'b0, '0);
        // double release goes unnoticed while the stack is not full
        send_request(1'b1, 24'd4);
        send_request(1'b1, 24'd4);
        send_request(1'b0, '0);
        settle();
        write_reg(fbpa_pkg::CFG_SLOT_SIZE, '0);
        write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 17'd1);
        send_request(1'b0, '0);
        send_request(1'b0, '0);
        send_request(1'b1, 24'd9);
        send_request(1'b1, 24'd4);
        send_request(1'b1, 24'd4);
        settle();
        write_reg(fbpa_pkg::CFG_BLOCK_COUNT, '0);
        send_request(1'b0, '0);
        settle();
        write_reg(fbpa_pkg::CFG_SLOT_SIZE, 17'h1FFFF);
        write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 17'd511);
        send_request(1'b0, '0);
        send_request(1'b1, 24'd131075);
        settle();
    endtask

    task phase_config(int p);
        case (p)
            0:
            begin
                write_reg(fbpa_pkg::CFG_SLOT_SIZE, 17'd68);
                write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 17'd256);
            end
            1:
            begin
                write_reg(fbpa_pkg::CFG_SLOT_SIZE, 17'd5);
                write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 17'd1);
            end
            2:
            begin
                write_reg(fbpa_pkg::CFG_SLOT_SIZE, 17'h1FFFF);
                write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 17'd256);
            end
            3:
            begin
                write_reg(fbpa_pkg::CFG_SLOT_SIZE, 17'd4);
                write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 17'd2);
            end
            4:
            begin
                write_reg(fbpa_pkg::CFG_SLOT_SIZE, 17'd65536);
                write_reg(fbpa_pkg::CFG_BLOCK_COUNT, fbpa_pkg::CFG_DATA_W'($urandom));
            end
            default:
            begin
                write_reg(fbpa_pkg::CFG_BLOCK_COUNT, 17'($urandom_range(1, 40)));
                if ($urandom_range(0, 1))
                    write_reg(fbpa_pkg::CFG_SLOT_SIZE, 17'($urandom_range(0, 300)));
                else
                    write_reg(fbpa_pkg::CFG_SLOT_SIZE, fbpa_pkg::CFG_DATA_W'($urandom));
            end
        endcase
    endtask

    initial
    begin
        int acq_pct;
        pool = new;
        pool.clear();
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        req.valid          <= 1'b0;
        req.req_type       <= 1'b0;
        req.release_offset <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(3);
        directed();

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            set_mode(0);
            phase_config(p);
            // slot size change alone keeps the stack contents
            if (p == 5)
                write_reg(fbpa_pkg::CFG_SLOT_SIZE, 17'($urandom_range(5, 120)));
            set_mode(p % 4);
            acq_pct = 50;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % CHUNK == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: acq_pct = 15;
                        1: acq_pct = 50;
                        2: acq_pct = 85;
                        default: acq_pct = 97;
                    endcase
                    if (p == 2)
                        acq_pct = 97;
                end
                random_item(acq_pct);
            end
        end

        settle();
        repeat (32) @(posedge clk);
        $display("%0d requests, %0d register writes", requests, cfg_writes);
        $display("results: %0d ok, %0d pool empty, %0d bad address, %0d overflow",
                 pool.status_seen[fbpa_pkg::ST_OK], pool.status_seen[fbpa_pkg::ST_EMPTY],
                 pool.status_seen[fbpa_pkg::ST_BAD], pool.status_seen[fbpa_pkg::ST_OVERFLOW]);
        if (pool.errors == 0 && pool.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_if.sv
rtl/core/fbpa_ram.sv
rtl/core/fbpa_div.sv
rtl/core/fixed_block_pool_allocator.sv
test/tb_top.sv
